### hw/rtl/tlvw_pkg.sv
package tlvw_pkg;

  // header is a 16-bit type followed by a 16-bit length
  localparam int unsigned HdrBytes = 4;

  typedef enum logic [1:0] {
    KindDesc   = 2'd0,
    KindAccept = 2'd1,
    KindShort  = 2'd2,
    KindBadLen = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    PhIdle   = 3'b001,
    PhHeader = 3'b010,
    PhBody   = 3'b100
  } phase_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] param_type;
    logic [15:0] param_offset;
    logic [15:0] param_length;
    logic        last;
  } result_t;

endpackage

### hw/rtl/tlvw_if.sv
interface tlvw_in_if;
  logic        valid;
  logic        ready;
  logic        action;
  logic [15:0] block_length;
  logic [7:0]  data_byte;

  modport source (output valid, output action, output block_length, output data_byte,
                  input ready);
  modport sink (input valid, input action, input block_length, input data_byte,
                output ready);
endinterface

interface tlvw_out_if;
  logic                valid;
  logic                ready;
  tlvw_pkg::kind_e     kind;
  logic [15:0]         param_type;
  logic [15:0]         param_offset;
  logic [15:0]         param_length;
  logic                last;

  modport source (output valid, output kind, output param_type, output param_offset,
                  output param_length, output last, input ready);
  modport sink (input valid, input kind, input param_type, input param_offset,
                input param_length, input last, output ready);
endinterface

### hw/rtl/tlv_parameter_walker.sv
// channel | dir | payload                                          | results per beat
// in_i    | in  | action, block_length, data_byte                  | 0, 1 or 2
// out_o   | out | kind, param_type, param_offset, param_length, last | one per beat
//
// one input beat is taken per cycle while ready is high; its results land in a 4-entry result
// queue on the next edge and can leave on that following cycle
// ready on in_i depends only on the queue fill (at most 2 held), so a beat
// that makes two results never overflows and a stalled output stops input
// reset clears the walker to idle and empties the queue
module tlv_parameter_walker (
  input  logic       clk_i,
  input  logic       rst_ni,
  tlvw_in_if.sink    in_i,
  tlvw_out_if.source out_o
);

  // walker state
  tlvw_pkg::phase_e phase_q, phase_d;
  logic [15:0]      rem_q, rem_d;        // block bytes not yet received
  logic [1:0]       hdr_idx_q, hdr_idx_d;
  logic [15:0]      cur_type_q, cur_type_d;
  logic [15:0]      cur_len_q, cur_len_d;
  logic [15:0]      start_q, start_d;    // offset of the current parameter
  logic [15:0]      body_q, body_d;      // value and pad bytes left to skip

  // results produced by the beat on the input
  tlvw_pkg::result_t res0, res1;
  logic [1:0]        n_res;

  // result queue
  tlvw_pkg::result_t fifo_q [4];
  logic [1:0]        wr_ptr_q, rd_ptr_q;
  logic [2:0]        count_q;

  logic in_fire, out_fire;

  // scratch for the header close-out
  logic [15:0] len_full;
  logic [16:0] room, padded, used;
  logic        bad_len;
  logic        np_go;
  tlvw_pkg::result_t np_res;

  assign in_i.ready = (count_q <= 3'd2);
  assign in_fire    = in_i.valid & in_i.ready;
  assign out_fire   = out_o.valid & out_o.ready;

  always_comb begin
    phase_d    = phase_q;
    rem_d      = rem_q;
    hdr_idx_d  = hdr_idx_q;
    cur_type_d = cur_type_q;
    cur_len_d  = cur_len_q;
    start_d    = start_q;
    body_d     = body_q;
    res0       = '0;
    res1       = '0;
    n_res      = 2'd0;
    np_go      = 1'b0;
    np_res     = '0;
    len_full   = {cur_len_q[7:0], in_i.data_byte};
    room       = {1'b0, rem_d} + 17'(tlvw_pkg::HdrBytes);
    padded     = ({1'b0, len_full} + 17'd3) & ~17'd3;
    used       = '0;
    bad_len    = 1'b0;

    if (!in_i.action) begin
      // begin: open a new block, abandoning any block in progress
      rem_d   = in_i.block_length;
      start_d = '0;
      body_d  = '0;
      np_go   = 1'b1;
    end else begin
      case (phase_q)
        tlvw_pkg::PhHeader: begin
          if (rem_q != '0) rem_d = rem_q - 16'd1;
          if (!hdr_idx_q[1]) cur_type_d = {cur_type_q[7:0], in_i.data_byte};
          else               cur_len_d  = len_full;
          hdr_idx_d = hdr_idx_q + 2'd1;
          room      = {1'b0, rem_d} + 17'(tlvw_pkg::HdrBytes);
          if (hdr_idx_q == 2'd3) begin
            bad_len = (len_full < 16'(tlvw_pkg::HdrBytes)) || ({1'b0, len_full} > room);
            if (bad_len) begin
              res0.kind         = tlvw_pkg::KindBadLen;
              res0.param_offset = start_q;
              res0.param_length = len_full;
              n_res             = 2'd1;
              phase_d           = tlvw_pkg::PhIdle;
            end else begin
              // block may end inside the final padding
              used              = (padded < room) ? padded : room;
              res0.kind         = tlvw_pkg::KindDesc;
              res0.param_type   = cur_type_q;
              res0.param_offset = start_q;
              res0.param_length = len_full;
              n_res             = 2'd1;
              body_d            = 16'(used - 17'(tlvw_pkg::HdrBytes));
              start_d           = start_q + used[15:0];
              if (body_d == '0) np_go = 1'b1;
              else              phase_d = tlvw_pkg::PhBody;
            end
          end
        end
        tlvw_pkg::PhBody: begin
          if (rem_q != '0)  rem_d  = rem_q - 16'd1;
          if (body_q != '0) body_d = body_q - 16'd1;
          if (body_d == '0) np_go = 1'b1;
        end
        default: begin
          // idle: stray data bytes are dropped
        end
      endcase
    end

    // end of a parameter or start of a block: accepted, short tail or next header
    if (np_go) begin
      if (rem_d < 16'(tlvw_pkg::HdrBytes)) begin
        np_res.kind         = (rem_d == '0) ? tlvw_pkg::KindAccept : tlvw_pkg::KindShort;
        np_res.param_offset = start_d;
        phase_d             = tlvw_pkg::PhIdle;
        if (n_res == 2'd0) res0 = np_res;
        else               res1 = np_res;
        n_res = n_res + 2'd1;
      end else begin
        phase_d    = tlvw_pkg::PhHeader;
        hdr_idx_d  = '0;
        cur_type_d = '0;
        cur_len_d  = '0;
      end
    end

    // mark the final result of this beat
    if (n_res == 2'd1) res0.last = 1'b1;
    if (n_res == 2'd2) res1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= tlvw_pkg::PhIdle;
      rem_q      <= '0;
      hdr_idx_q  <= '0;
      cur_type_q <= '0;
      cur_len_q  <= '0;
      start_q    <= '0;
      body_q     <= '0;
    end else if (in_fire) begin
      phase_q    <= phase_d;
      rem_q      <= rem_d;
      hdr_idx_q  <= hdr_idx_d;
      cur_type_q <= cur_type_d;
      cur_len_q  <= cur_len_d;
      start_q    <= start_d;
      body_q     <= body_d;
    end
  end

  // queue pointers and fill
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (in_fire) wr_ptr_q <= wr_ptr_q + n_res;
      if (out_fire) rd_ptr_q <= rd_ptr_q + 2'd1;
      count_q <= count_q + (in_fire ? {1'b0, n_res} : 3'd0) - {2'b0, out_fire};
    end
  end

  // queue payload, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_fire && n_res != 2'd0) fifo_q[wr_ptr_q] <= res0;
    if (in_fire && n_res == 2'd2) fifo_q[wr_ptr_q + 2'd1] <= res1;
  end

  assign out_o.valid        = (count_q != '0);
  assign out_o.kind         = fifo_q[rd_ptr_q].kind;
  assign out_o.param_type   = fifo_q[rd_ptr_q].param_type;
  assign out_o.param_offset = fifo_q[rd_ptr_q].param_offset;
  assign out_o.param_length = fifo_q[rd_ptr_q].param_length;
  assign out_o.last         = fifo_q[rd_ptr_q].last;

endmodule

### hw/rtl/tlvw_checker.sv
module tlvw_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input tlvw_pkg::kind_e kind_i,
  input logic [15:0]     param_type_i,
  input logic [15:0]     param_offset_i,
  input logic [15:0]     param_length_i,
  input logic            last_i
);

  // stalled beat holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) &&
    $stable(param_offset_i) && $stable(param_length_i) && $stable(last_i))
    else $error("stalled output beat changed");

  // nothing comes out right after reset
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("output valid right after reset");

  // block verdicts and errors always close the beat's results
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i != tlvw_pkg::KindDesc |-> last_i)
    else $error("verdict without last");

  // a descriptor only comes from a length of at least a header
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && kind_i == tlvw_pkg::KindDesc |->
    param_length_i >= 16'(tlvw_pkg::HdrBytes))
    else $error("descriptor with short length");

  // accepted and short header carry no type or length
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == tlvw_pkg::KindAccept || kind_i == tlvw_pkg::KindShort) |->
    param_type_i == '0 && param_length_i == '0)
    else $error("verdict with type or length");

endmodule

bind tlv_parameter_walker tlvw_checker u_tlvw_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .kind_i         (out_o.kind),
  .param_type_i   (out_o.param_type),
  .param_offset_i (out_o.param_offset),
  .param_length_i (out_o.param_length),
  .last_i         (out_o.last)
);

### bench/tlv_parameter_walker_tb.sv
`timescale 1ns / 100ps

module tlv_parameter_walker_tb;

  localparam int CLK_PERIOD = 4;
  localparam int RESET_CYCLES = 10;
  // rough count of random beats, not counting bytes the walker just drops
  localparam int RANDOM_BEATS = 1100;
  // tail of the run with both sides streaming at full rate
  localparam int CALM_BEATS = 150;
  // beats between changes of the idle/stall mix
  localparam int MIX_SPAN = 120;
  // results leave the 4-entry queue once ready is high
  localparam int DRAIN_CYCLES = 16;
  // worst case per beat is an idle burst plus two results, each held by a
  // stall burst; this is several times that over the whole run
  localparam int TIMEOUT_NS = 2_000_000;
  // row flag: expected results come from the predictor, not the row
  localparam int FROM_WALKER = -1;
  localparam tlvw_pkg::result_t NoRes = '0;

  // one stimulus row; n_expect >= 0 means the row carries its own results
  typedef struct {
    logic              act;
    logic [15:0]       blen;
    logic [7:0]        dbyte;
    int                n_expect;
    tlvw_pkg::result_t r0;
    tlvw_pkg::result_t r1;
  } stim_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  tlvw_in_if  in_if ();
  tlvw_out_if out_if ();

  tlv_parameter_walker dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // walker state mirror, advanced once per accepted input beat
  // ---------------------------------------------------------------------------
  tlvw_pkg::phase_e wk_phase;
  logic [15:0] wk_left;   // block bytes not yet seen
  logic [1:0]  wk_idx;    // header byte position
  logic [15:0] wk_type;
  logic [15:0] wk_len;
  logic [15:0] wk_start;  // block offset of the current parameter
  logic [15:0] wk_skip;   // value and pad bytes still to pass over

  tlvw_pkg::result_t walk_out[$];        // results of the beat just walked
  tlvw_pkg::result_t pending_results[$]; // results the dut still owes, oldest first
  stim_row_t drive_row;                  // row currently on the input channel
  stim_row_t directed_rows[$];

  int mismatch_cnt = 0;
  int beats_sent = 0;
  int gap_pct = 15;    // chance per beat of an idle burst on the input side
  int stall_pct = 15;  // chance per cycle of a stall burst on the output side
  int stall_left = 0;

  function automatic tlvw_pkg::result_t mk_res(tlvw_pkg::kind_e k, logic [15:0] t,
                                               logic [15:0] off, logic [15:0] len,
                                               logic lst);
    tlvw_pkg::result_t r;
    r.kind = k;
    r.param_type = t;
    r.param_offset = off;
    r.param_length = len;
    r.last = lst;
    return r;
  endfunction

  // a parameter or the block start is done: accept, short tail, or next header
  task automatic close_param();
    if (wk_left == 16'd0) begin
      walk_out.push_back(mk_res(tlvw_pkg::KindAccept, 16'd0, wk_start, 16'd0, 1'b0));
      wk_phase = tlvw_pkg::PhIdle;
    end else if (wk_left < tlvw_pkg::HdrBytes) begin
      walk_out.push_back(mk_res(tlvw_pkg::KindShort, 16'd0, wk_start, 16'd0, 1'b0));
      wk_phase = tlvw_pkg::PhIdle;
    end else begin
      wk_phase = tlvw_pkg::PhHeader;
      wk_idx = 2'd0;
      wk_type = 16'd0;
      wk_len = 16'd0;
    end
  endtask

  task automatic walk_byte(logic act, logic [15:0] blen, logic [7:0] b);
    int unsigned       room;
    int unsigned       padded;
    int unsigned       used;
    tlvw_pkg::result_t tail;
    walk_out.delete();
    if (!act) begin
      // begin drops whatever block was in flight
      wk_left = blen;
      wk_start = 16'd0;
      wk_skip = 16'd0;
      close_param();
    end else if (wk_phase == tlvw_pkg::PhHeader) begin
      if (wk_left != 16'd0) wk_left = wk_left - 16'd1;
      if (wk_idx < 2'd2) wk_type = {wk_type[7:0], b};
      else wk_len = {wk_len[7:0], b};
      wk_idx = wk_idx + 2'd1;
      if (wk_idx == 2'd0) begin
        room = wk_left + tlvw_pkg::HdrBytes;
        if (wk_len < tlvw_pkg::HdrBytes || wk_len > room) begin
          walk_out.push_back(mk_res(tlvw_pkg::KindBadLen, 16'd0, wk_start, wk_len, 1'b0));
          wk_phase = tlvw_pkg::PhIdle;
        end else begin
          // pad to a multiple of 4 bytes, but the block may stop inside the padding
          padded = (wk_len + 32'd3) & ~32'd3;
          used = (padded < room) ? padded : room;
          walk_out.push_back(mk_res(tlvw_pkg::KindDesc, wk_type, wk_start, wk_len, 1'b0));
          wk_skip = 16'(used - tlvw_pkg::HdrBytes);
          wk_start = wk_start + 16'(used);
          if (wk_skip == 16'd0) close_param();
          else wk_phase = tlvw_pkg::PhBody;
        end
      end
    end else if (wk_phase == tlvw_pkg::PhBody) begin
      if (wk_left != 16'd0) wk_left = wk_left - 16'd1;
      if (wk_skip != 16'd0) wk_skip = wk_skip - 16'd1;
      if (wk_skip == 16'd0) close_param();
    end
    // stray bytes while idle fall through with no result
    if (walk_out.size() > 0) begin
      tail = walk_out.pop_back();
      tail.last = 1'b1;
      walk_out.push_back(tail);
    end
  endtask

  // ---------------------------------------------------------------------------
  // checking: both handshakes sampled in one process at the rising edge
  // ---------------------------------------------------------------------------
  task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatch_cnt++;
    end
  endtask

  task automatic check_result();
    tlvw_pkg::result_t want;
    if (pending_results.size() == 0) begin
      $error("result beat with nothing outstanding: kind %0d offset %0d",
             out_if.kind, out_if.param_offset);
      mismatch_cnt++;
    end else begin
      want = pending_results.pop_front();
      check_field("kind", 16'(want.kind), 16'(out_if.kind));
      check_field("param_type", want.param_type, out_if.param_type);
      check_field("param_offset", want.param_offset, out_if.param_offset);
      check_field("param_length", want.param_length, out_if.param_length);
      check_field("last", 16'(want.last), 16'(out_if.last));
    end
  endtask

  task automatic accept_beat();
    walk_byte(in_if.action, in_if.block_length, in_if.data_byte);
    if (drive_row.n_expect == FROM_WALKER) begin
      foreach (walk_out[i]) pending_results.push_back(walk_out[i]);
    end else begin
      // hand-typed rows still advance the mirror, its results are dropped
      if (drive_row.n_expect >= 1) pending_results.push_back(drive_row.r0);
      if (drive_row.n_expect >= 2) pending_results.push_back(drive_row.r1);
    end
  endtask

  // output beat checked before the input beat is walked, so a result can
  // never be matched against an expectation created on the same edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) check_result();
      if (in_if.valid && in_if.ready) accept_beat();
    end
  end

  // ---------------------------------------------------------------------------
  // output side: ready, dropped in random stall bursts that span whole cycles
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (stall_left > 0) begin
        stall_left--;
        out_if.ready <= 1'b0;
      end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
        stall_left = $urandom_range(15);
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------
  // valid stays high across back-to-back beats; it only drops for an idle burst
  task automatic send_beat(stim_row_t s, bit counts);
    int gap;
    @(negedge clk_i);
    drive_row = s;
    in_if.valid <= 1'b1;
    in_if.action <= s.act;
    in_if.block_length <= s.blen;
    in_if.data_byte <= s.dbyte;
    do @(posedge clk_i); while (!in_if.ready);
    if (counts) beats_sent++;
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      gap = $urandom_range(16, 1);
      @(negedge clk_i);
      in_if.valid <= 1'b0;
      in_if.data_byte <= 8'($urandom_range(255));
      repeat (gap - 1) @(negedge clk_i);
    end
  endtask

  task automatic send_begin(logic [15:0] blen);
    send_beat('{1'b0, blen, 8'($urandom_range(255)), FROM_WALKER, NoRes, NoRes}, 1'b1);
  endtask

  task automatic send_data(logic [7:0] b);
    send_beat('{1'b1, 16'($urandom_range(65535)), b, FROM_WALKER, NoRes, NoRes}, 1'b1);
  endtask

  // bytes sent while the walker sits idle; they do not count toward the run
  task automatic send_stray(int n);
    repeat (n)
      send_beat('{1'b1, 16'($urandom_range(65535)), 8'($urandom_range(255)),
                  FROM_WALKER, NoRes, NoRes}, 1'b0);
  endtask

  task automatic add_row(logic act, logic [15:0] blen, logic [7:0] b, int n,
                         tlvw_pkg::result_t r0, tlvw_pkg::result_t r1);
    stim_row_t s;
    s.act = act;
    s.blen = blen;
    s.dbyte = b;
    s.n_expect = n;
    s.r0 = r0;
    s.r1 = r1;
    directed_rows.push_back(s);
  endtask

  // one block: mostly well-formed parameters with random content, with some
  // bad lengths, cut-off headers, tiny blocks, abandoned large blocks and pure noise
  task automatic random_block();
    int unsigned sel;
    int unsigned p;
    int unsigned blen;
    int unsigned rem;
    int unsigned plen;
    int unsigned padded;
    int unsigned used;
    int          n;
    sel = $urandom_range(99);
    if (sel < 8) begin
      // pure noise: random begin and random bytes
      send_begin(16'($urandom_range(65535)));
      repeat ($urandom_range(12)) send_data(8'($urandom_range(255)));
      return;
    end
    if (sel < 14) blen = $urandom_range(65535, 49);  // large, can be left unfinished
    else if (sel < 22) blen = $urandom_range(3);
    else blen = $urandom_range(60, 4);
    send_begin(16'(blen));
    rem = blen;
    n = 0;
    while (rem >= tlvw_pkg::HdrBytes && n < 8) begin
      n++;
      p = $urandom_range(99);
      if (p < 6) begin
        // header cut off by the next begin
        repeat ($urandom_range(3, 1)) send_data(8'($urandom_range(255)));
        return;
      end
      if (p < 12) plen = $urandom_range(3);
      else if (p < 18 && rem < 65535) plen = $urandom_range(65535, rem + 1);
      else if (p < 32 && rem <= 64) plen = rem - $urandom_range((rem - 4 < 3) ? rem - 4 : 3);
      else plen = $urandom_range((rem < 24) ? rem : 24, 4);
      send_data(8'($urandom_range(255)));
      send_data(8'($urandom_range(255)));
      send_data(8'(plen >> 8));
      send_data(8'(plen));
      if (plen < tlvw_pkg::HdrBytes || plen > rem) begin
        // walker drops everything until the next begin
        if ($urandom_range(9) < 3) send_stray($urandom_range(4, 1));
        return;
      end
      padded = (plen + 3) & ~32'd3;
      used = (padded < rem) ? padded : rem;
      repeat (used - tlvw_pkg::HdrBytes) send_data(8'($urandom_range(255)));
      rem = rem - used;
    end
    if (rem < tlvw_pkg::HdrBytes && $urandom_range(9) == 0) send_stray($urandom_range(3, 1));
  endtask

  initial begin
    int next_shift;
    int total;
    rst_ni = 1'b0;
    in_if.valid = 1'b0;
    in_if.action = 1'b0;
    in_if.block_length = 16'd0;
    in_if.data_byte = 8'd0;
    out_if.ready = 1'b0;
    wk_phase = tlvw_pkg::PhIdle;
    wk_left = 16'd0;
    wk_idx = 2'd0;
    wk_type = 16'd0;
    wk_len = 16'd0;
    wk_start = 16'd0;
    wk_skip = 16'd0;
    drive_row = '{1'b0, 16'd0, 8'd0, FROM_WALKER, NoRes, NoRes};

    // directed rows
    // empty block and tiny block answer at once
    add_row(1'b0, 16'd0, 8'h00, 1,
            mk_res(tlvw_pkg::KindAccept, 16'd0, 16'd0, 16'd0, 1'b1), NoRes);
    add_row(1'b0, 16'd1, 8'h00, 1,
            mk_res(tlvw_pkg::KindShort, 16'd0, 16'd0, 16'd0, 1'b1), NoRes);
    // largest block, abandoned by the next begin
    add_row(1'b0, 16'hFFFF, 8'hFF, 0, NoRes, NoRes);
    // 13 bytes: header-only parameter of type ffff, then a length-5 parameter
    // padded to 8, leaving a one-byte tail
    add_row(1'b0, 16'd13, 8'h00, FROM_WALKER, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'hFF, FROM_WALKER, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'hFF, FROM_WALKER, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'h00, FROM_WALKER, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'h04, FROM_WALKER, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'h00, FROM_WALKER, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'h00, FROM_WALKER, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'h00, FROM_WALKER, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'h05, FROM_WALKER, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'hAA, FROM_WALKER, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'h55, FROM_WALKER, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'h00, FROM_WALKER, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'hFF, FROM_WALKER, NoRes, NoRes);
    // length 3 is below the header size
    add_row(1'b0, 16'd8, 8'h00, 0, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'h00, 0, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'h01, 0, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'h00, 0, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'h03, 1,
            mk_res(tlvw_pkg::KindBadLen, 16'd0, 16'd0, 16'd3, 1'b1), NoRes);
    // stray byte after an error is dropped
    add_row(1'b1, 16'd0, 8'h5A, 0, NoRes, NoRes);
    // length ffff runs past a 4-byte block
    add_row(1'b0, 16'd4, 8'h00, 0, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'h12, 0, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'h34, 0, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'hFF, 0, NoRes, NoRes);
    add_row(1'b1, 16'd0, 8'hFF, 1,
            mk_res(tlvw_pkg::KindBadLen, 16'd0, 16'd0, 16'hFFFF, 1'b1), NoRes);

    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (directed_rows[i]) send_beat(directed_rows[i], 1'b1);

    // random part; the idle/stall mix changes every so often, calm at the end
    total = beats_sent + RANDOM_BEATS;
    next_shift = beats_sent;
    while (beats_sent < total) begin
      if (beats_sent >= total - CALM_BEATS) begin
        gap_pct = 0;
        stall_pct = 0;
      end else if (beats_sent >= next_shift) begin
        case ($urandom_range(3))
          0: gap_pct = 0;
          1: gap_pct = 5;
          2: gap_pct = 20;
          default: gap_pct = 50;
        endcase
        case ($urandom_range(3))
          0: stall_pct = 0;
          1: stall_pct = 5;
          2: stall_pct = 20;
          default: stall_pct = 50;
        endcase
        next_shift = next_shift + MIX_SPAN;
      end
      random_block();
    end

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    // catch any extra result the dut might still push out
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("tlv_parameter_walker_tb: clean");
    end else begin
      $display("tlv_parameter_walker_tb: errors");
    end
    $finish;
  end

  // watchdog against a hung handshake
  initial begin
    #(TIMEOUT_NS);
    $display("tlv_parameter_walker_tb: errors");
    $finish;
  end

endmodule
